// ----- rtl/core/extended_float_add_mul_div_macros.svh -----
// ----------------------------------------------------------------------------
// extended float unit assertion macros
// clocked assertion helpers used by the unit's sequencer
// ----------------------------------------------------------------------------
`ifndef EXTENDED_FLOAT_ADD_MUL_DIV_MACROS_SVH
`define EXTENDED_FLOAT_ADD_MUL_DIV_MACROS_SVH

// same-cycle implication, disabled in reset
`define EFAM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define EFAM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/efam_pkg.sv -----
// ----------------------------------------------------------------------------
// efam_pkg
// types and constants of the extended float add/mul/div unit
// ----------------------------------------------------------------------------
package efam_pkg;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [1:0] RM_NEAR = 2'd0;
	localparam logic [1:0] RM_DOWN = 2'd1;
	localparam logic [1:0] RM_UP   = 2'd2;
	localparam logic [1:0] RM_ZERO = 2'd3;

	localparam logic [14:0] EXP_BIAS = 15'h3fff;
	localparam logic [14:0] EXP_TOP  = 15'h7ffe;
	localparam logic [14:0] EXP_ONE  = 15'h0001;
	localparam logic [14:0] EXP_ALL1 = 15'h7fff;

	localparam logic signed [17:0] E_MIN = -18'sd16382;
	localparam logic signed [17:0] E_MAX = 18'sd16383;

	localparam logic [63:0] SIG_INT  = 64'h8000_0000_0000_0000;
	localparam logic [63:0] SIG_QNAN = 64'hc000_0000_0000_0000;

	typedef struct packed {
		logic        sign;
		logic [14:0] exp;
		logic [63:0] sig;
	} xval_t;

	typedef struct packed {
		logic load;
		logic classify;
		logic align;
		logic addsub;
		logic negate;
		logic mul;
		logic prenorm;
		logic divide;
		logic norm;
		logic round;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       special;
		logic       cancel;
		logic       mul_last;
		logic       pre_done;
		logic       div_last;
		logic       norm_done;
	} sts_t;

endpackage

// ----- rtl/core/efam_ctrl.sv -----
// ----------------------------------------------------------------------------
// efam_ctrl
// sequencer of the extended float unit: steps the datapath per operation
// ----------------------------------------------------------------------------
`include "extended_float_add_mul_div_macros.svh"

module efam_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  efam_pkg::sts_t sts,
	output efam_pkg::cmd_t cmd
);
	import efam_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE    = 11'b000_0000_0001,
		ST_CLASS   = 11'b000_0000_0010,
		ST_ALIGN   = 11'b000_0000_0100,
		ST_ADDSUB  = 11'b000_0000_1000,
		ST_NEG     = 11'b000_0001_0000,
		ST_MUL     = 11'b000_0010_0000,
		ST_PRENORM = 11'b000_0100_0000,
		ST_DIV     = 11'b000_1000_0000,
		ST_NORM    = 11'b001_0000_0000,
		ST_ROUND   = 11'b010_0000_0000,
		ST_FINISH  = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   valid_q;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = valid_q;
	assign out_free = !valid_q || m_tready;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d = ST_CLASS;
				end
			end
			ST_CLASS: begin
				cmd.classify = 1'b1;
				if (sts.special) begin
					state_d = ST_FINISH;
				end else begin
					unique case (sts.op)
						OP_ADD, OP_SUB: state_d = ST_ALIGN;
						OP_MUL: state_d = ST_MUL;
						OP_DIV: state_d = ST_PRENORM;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_ALIGN: begin
				cmd.align = 1'b1;
				state_d = ST_ADDSUB;
			end
			ST_ADDSUB: begin
				cmd.addsub = 1'b1;
				state_d = ST_NEG;
			end
			ST_NEG: begin
				cmd.negate = 1'b1;
				state_d = sts.cancel ? ST_FINISH : ST_NORM;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				if (sts.mul_last) state_d = ST_NORM;
			end
			ST_PRENORM: begin
				cmd.prenorm = 1'b1;
				if (sts.pre_done) state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.divide = 1'b1;
				if (sts.div_last) state_d = ST_NORM;
			end
			ST_NORM: begin
				cmd.norm = 1'b1;
				if (sts.norm_done) state_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) valid_q <= 1'b1;
			else if (m_tready) valid_q <= 1'b0;
		end
	end

	`EFAM_ASSERT_NEXT(a_accept_to_class, clk, arst_n, s_tvalid && s_tready, state_q == ST_CLASS, "accepted transfer did not start classification")
	`EFAM_ASSERT_NOW(a_emit_free, clk, arst_n, cmd.emit, !valid_q || m_tready, "result emitted over a pending transfer")
	`EFAM_ASSERT_NEXT(a_hold_result, clk, arst_n, valid_q && !m_tready, valid_q, "pending result dropped")
	`EFAM_ASSERT_NEXT(a_div_to_norm, clk, arst_n, state_q == ST_DIV && sts.div_last, state_q == ST_NORM, "divide did not hand over to normalize")

endmodule

// ----- rtl/core/efam_dp.sv -----
// ----------------------------------------------------------------------------
// efam_dp
// datapath: operand registers, align/add, 32x32 multiplier, restoring
// divider, one-bit normalizer and rounding
// ----------------------------------------------------------------------------
module efam_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic [1:0]     cfg_wr_data,
	input  logic [159:0]   s_tdata,
	input  logic [1:0]     s_tuser,
	input  efam_pkg::cmd_t cmd,
	output efam_pkg::sts_t sts,
	output logic [79:0]    m_tdata
);
	import efam_pkg::*;

	function automatic logic signed [17:0] true_exp(input logic [14:0] e);
		logic [14:0] t;
		t = (e == 15'd0) ? EXP_ONE : e;
		return $signed({3'b000, t}) - $signed({3'b000, EXP_BIAS});
	endfunction

	logic [1:0]   mode_q;
	logic [1:0]   op_q;
	logic         as_q, bs_q;
	logic [14:0]  ae_q, be_q;
	logic [63:0]  am_q, bm_q;
	logic [127:0] s_q, t_q;
	logic signed [17:0] e_q;
	logic         sign_q, osign_q;
	logic         sub_q, neg_q;
	logic [6:0]   cnt_q;
	logic [63:0]  pp_q;
	logic [1:0]   ppsh_q;
	logic [64:0]  x_q;
	logic [63:0]  q_q;
	logic         g_q, st_q;
	logic [14:0]  rbe_q;
	logic         fixed_q;
	xval_t        fx_q, out_q;

	// classification
	logic  a_unsup, b_unsup, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, xs;
	logic  spec;
	xval_t sres, dnan;

	assign a_unsup = (ae_q == 15'd0) ? am_q[63] : !am_q[63];
	assign b_unsup = (be_q == 15'd0) ? bm_q[63] : !bm_q[63];
	assign a_nan   = (ae_q == EXP_ALL1) && (am_q[62:0] != '0);
	assign b_nan   = (be_q == EXP_ALL1) && (bm_q[62:0] != '0);
	assign a_inf   = (ae_q == EXP_ALL1) && (am_q[62:0] == '0);
	assign b_inf   = (be_q == EXP_ALL1) && (bm_q[62:0] == '0);
	assign a_zero  = (ae_q == 15'd0) && (am_q == '0);
	assign b_zero  = (be_q == 15'd0) && (bm_q == '0);
	assign xs      = as_q ^ bs_q;
	assign dnan    = '{sign: 1'b1, exp: EXP_ALL1, sig: SIG_QNAN};

	always_comb begin
		spec = 1'b1;
		sres = dnan;
		priority if (a_unsup || b_unsup) begin
			sres = dnan;
		end else if (a_nan && b_nan && as_q && !bs_q) begin
			sres = '{sign: bs_q, exp: be_q, sig: bm_q};
		end else if (a_nan) begin
			sres = '{sign: as_q, exp: ae_q, sig: am_q};
		end else if (b_nan) begin
			sres = '{sign: bs_q, exp: be_q, sig: bm_q};
		end else begin
			unique case (op_q)
				OP_ADD, OP_SUB: begin
					priority if (a_inf && b_inf && (as_q != bs_q)) sres = dnan;
					else if (a_inf) sres = '{sign: as_q, exp: ae_q, sig: am_q};
					else if (b_inf) sres = '{sign: bs_q, exp: be_q, sig: bm_q};
					else spec = 1'b0;
				end
				OP_MUL: begin
					priority if ((a_inf || b_inf) && (a_zero || b_zero)) sres = dnan;
					else if (a_inf || b_inf) sres = '{sign: xs, exp: EXP_ALL1, sig: SIG_INT};
					else spec = 1'b0;
				end
				OP_DIV: begin
					priority if (a_inf && b_inf) sres = dnan;
					else if (a_inf) sres = '{sign: xs, exp: EXP_ALL1, sig: SIG_INT};
					else if (b_inf) sres = '{sign: xs, exp: 15'd0, sig: 64'd0};
					else if (b_zero && a_zero) sres = dnan;
					else if (b_zero) sres = '{sign: xs, exp: EXP_ALL1, sig: SIG_INT};
					else if (a_zero) sres = '{sign: xs, exp: 15'd0, sig: 64'd0};
					else spec = 1'b0;
				end
				default: spec = 1'b0;
			endcase
		end
	end

	// alignment
	logic         swap;
	logic [14:0]  big_e, sml_e, diff;
	logic [63:0]  big_m, sml_m;
	logic [127:0] sml_x, sml_sh;
	logic         sml_lost;
	logic signed [17:0] dexp;

	assign swap     = ae_q < be_q;
	assign big_e    = swap ? be_q : ae_q;
	assign sml_e    = swap ? ae_q : be_q;
	assign big_m    = swap ? bm_q : am_q;
	assign sml_m    = swap ? am_q : bm_q;
	assign dexp     = true_exp(big_e) - true_exp(sml_e);
	assign diff     = dexp[14:0];
	assign sml_x    = {sml_m, 64'd0};
	assign sml_sh   = sml_x >> diff;
	assign sml_lost = |(sml_x & ~({128{1'b1}} << diff));

	// add / subtract
	logic [128:0] sum, dif;
	logic         eff_sub;
	assign eff_sub = sign_q != osign_q;
	assign sum     = {1'b0, s_q} + {1'b0, t_q};
	assign dif     = {1'b0, s_q} - {1'b0, t_q};

	// multiplier
	logic [31:0] mx, my;
	logic [63:0] prod;
	assign mx   = cnt_q[1] ? am_q[63:32] : am_q[31:0];
	assign my   = cnt_q[0] ? bm_q[63:32] : bm_q[31:0];
	assign prod = mx * my;

	// divider step
	logic        ge;
	logic [64:0] rem;
	assign ge  = x_q >= {1'b0, bm_q};
	assign rem = ge ? (x_q - {1'b0, bm_q}) : x_q;

	// normalize / round
	logic         s_zero, ovf, nrm;
	logic signed [17:0] nn;
	logic [7:0]   rn;
	logic [127:0] gmask, lmask, qsh;
	logic         to_max, away;

	assign s_zero = s_q == '0;
	assign ovf    = s_q[127] && (e_q > E_MAX);
	assign nrm    = s_q[127] && (e_q >= E_MIN);
	assign nn     = 18'sd64 + E_MIN - e_q;
	assign rn     = (e_q >= E_MIN) ? 8'd64 : ((nn > 18'sd128) ? 8'd129 : nn[7:0]);
	assign gmask  = 128'd1 << (rn - 8'd1);
	assign lmask  = ~({128{1'b1}} << rn) & ~gmask;
	assign qsh    = s_q >> rn;
	assign to_max = (mode_q == RM_ZERO) || (mode_q == RM_DOWN && !sign_q)
		|| (mode_q == RM_UP && sign_q);
	assign away   = (mode_q == RM_UP && !sign_q) || (mode_q == RM_DOWN && sign_q);

	logic        inc;
	logic [64:0] qinc;
	xval_t       rres;
	always_comb begin
		inc  = (g_q || st_q) && (away || (mode_q == RM_NEAR && g_q && (st_q || q_q[0])));
		qinc = {1'b0, q_q} + {64'd0, inc};
		rres.sign = sign_q;
		if (qinc[64]) begin
			rres.sig = SIG_INT;
			rres.exp = rbe_q + EXP_ONE;
		end else begin
			rres.sig = qinc[63:0];
			rres.exp = rbe_q;
		end
		if (rres.exp == 15'd0 && rres.sig[63]) rres.exp = EXP_ONE;
	end

	assign sts.op        = op_q;
	assign sts.special   = spec;
	assign sts.cancel    = sub_q && s_zero;
	assign sts.mul_last  = cnt_q == 7'd4;
	assign sts.pre_done  = am_q[63] && bm_q[63];
	assign sts.div_last  = cnt_q == 7'd127;
	assign sts.norm_done = s_q[127] || s_zero || (e_q <= E_MIN);

	assign m_tdata = {out_q.sig, out_q.exp, out_q.sign};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= RM_NEAR;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= s_tuser;
			as_q <= s_tdata[0];
			ae_q <= s_tdata[15:1];
			am_q <= s_tdata[79:16];
			bs_q <= s_tdata[80] ^ (s_tuser == OP_SUB);
			be_q <= s_tdata[95:81];
			bm_q <= s_tdata[159:96];
		end
		if (cmd.classify) begin
			fixed_q <= spec;
			fx_q    <= sres;
			s_q     <= '0;
			cnt_q   <= '0;
			sub_q   <= 1'b0;
			sign_q  <= xs;
			if (op_q == OP_MUL) e_q <= true_exp(ae_q) + true_exp(be_q) + 18'sd1;
			else e_q <= true_exp(ae_q) - true_exp(be_q);
		end
		if (cmd.align) begin
			s_q     <= {big_m, 64'd0};
			t_q     <= sml_sh | {127'd0, sml_lost};
			sign_q  <= swap ? bs_q : as_q;
			osign_q <= swap ? as_q : bs_q;
			e_q     <= true_exp(big_e);
		end
		if (cmd.addsub) begin
			sub_q <= eff_sub;
			neg_q <= eff_sub && dif[128];
			if (!eff_sub) begin
				if (sum[128]) begin
					s_q <= {1'b1, sum[127:2], sum[1] | sum[0]};
					e_q <= e_q + 18'sd1;
				end else begin
					s_q <= sum[127:0];
				end
			end else begin
				s_q <= dif[127:0];
			end
		end
		if (cmd.negate) begin
			if (sub_q && s_zero) begin
				fixed_q <= 1'b1;
				fx_q    <= '{sign: (mode_q == RM_DOWN), exp: 15'd0, sig: 64'd0};
			end else if (neg_q) begin
				s_q    <= -s_q;
				sign_q <= osign_q;
			end
		end
		if (cmd.mul) begin
			if (cnt_q < 7'd4) begin
				pp_q   <= prod;
				ppsh_q <= {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
			end
			if (cnt_q != 7'd0) s_q <= s_q + ({64'd0, pp_q} << {ppsh_q, 5'd0});
			cnt_q <= cnt_q + 7'd1;
		end
		if (cmd.prenorm) begin
			if (am_q[63] && bm_q[63]) begin
				x_q   <= {1'b0, am_q};
				s_q   <= '0;
				cnt_q <= '0;
			end else begin
				if (!am_q[63]) am_q <= {am_q[62:0], 1'b0};
				if (!bm_q[63]) bm_q <= {bm_q[62:0], 1'b0};
				e_q <= e_q - {17'd0, !am_q[63]} + {17'd0, !bm_q[63]};
			end
		end
		if (cmd.divide) begin
			x_q   <= {rem[63:0], 1'b0};
			s_q   <= {s_q[126:0], ge | ((cnt_q == 7'd127) && (rem[63:0] != '0))};
			cnt_q <= cnt_q + 7'd1;
		end
		if (cmd.norm) begin
			if (!(s_q[127] || s_zero || (e_q <= E_MIN))) begin
				s_q <= {s_q[126:0], 1'b0};
				e_q <= e_q - 18'sd1;
			end
		end
		if (cmd.round) begin
			q_q   <= qsh[63:0];
			g_q   <= |(s_q & gmask);
			st_q  <= |(s_q & lmask);
			rbe_q <= nrm ? 15'(e_q + $signed({3'b000, EXP_BIAS})) : 15'd0;
			if (s_zero) begin
				fixed_q <= 1'b1;
				fx_q    <= '{sign: sign_q, exp: 15'd0, sig: 64'd0};
			end else if (ovf) begin
				fixed_q <= 1'b1;
				fx_q    <= to_max ? '{sign: sign_q, exp: EXP_TOP, sig: {64{1'b1}}}
					: '{sign: sign_q, exp: EXP_ALL1, sig: SIG_INT};
			end else begin
				fixed_q <= 1'b0;
			end
		end
		if (cmd.emit) begin
			out_q <= fixed_q ? fx_q : rres;
		end
	end

endmodule

// ----- rtl/core/extended_float_add_mul_div.sv -----
// path from input transfer to result transfer: special operands go from classify to finish,
// exact cancellation ends after negate, add/sub and multiply take one normalize step per shift;
// divide adds the one-bit-per-cycle restoring divider (128 steps) and one prenormalize step
// per leading zero of the more denormal operand
// one request in flight; the next transfer is taken once the result sits in the output register
// reset: arst_n asynchronous active low, clears the sequencer, output valid and rounding mode
// ----------------------------------------------------------------------------
// extended_float_add_mul_div
// 80-bit extended format add, subtract, multiply and divide with stream ports
// ----------------------------------------------------------------------------
module extended_float_add_mul_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [1:0]   cfg_wr_data,   // rounding_mode
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [159:0] s_tdata,       // a_sign, a_exponent, a_significand, b_sign, b_exponent, b_significand
	input  logic [1:0]   s_tuser,       // req_type
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [79:0]  m_tdata        // result_sign, result_exponent, result_significand
);
	import efam_pkg::*;

	cmd_t cmd;
	sts_t sts;

	efam_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	efam_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.cmd         (cmd),
		.sts         (sts),
		.m_tdata     (m_tdata)
	);

endmodule
